/* hw/rtl/esd_pkg.sv */
// Shared types and character constants for the escape sequence decoder.
// No dependencies; esd_front, esd_back and the top level import this package.
`default_nettype none

package esd_pkg;

    // Character codes
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_DIG_0     = 8'h30;
    localparam logic [7:0] CH_DIG_9     = 8'h39;
    localparam logic [7:0] CH_LC_A      = 8'h61;
    localparam logic [7:0] CH_LC_F      = 8'h66;
    localparam logic [7:0] CH_UC_A      = 8'h41;
    localparam logic [7:0] CH_UC_F      = 8'h46;

    // Default depth of the queue between front and back
    localparam int ESD_QUEUE_DEPTH = 4;

    // A classified byte as it travels from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       is_bs;
        logic       is_x;
        logic       is_ws;
        logic       is_plus;
        logic       is_minus;
        logic       is_hex;
        logic [3:0] hex_val;
    } t_cls;

endpackage

`default_nettype wire

/* hw/rtl/esd_if.sv */
// Stream interfaces for the escape sequence decoder: input bytes and decoded bytes.
// Valid/ready handshake; a transfer happens when both are high at a rising edge.
`default_nettype none

interface esd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface esd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

/* hw/rtl/esd_front.sv */
// Front end: accepts input bytes, classifies them and holds them in a short queue.
// Depends on esd_pkg and esd_in_if.
`default_nettype none

module esd_front import esd_pkg::*; #(
    parameter int QUEUE_DEPTH = ESD_QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    esd_in_if.sink    i_in,
    output t_cls      o_q_item,
    output logic      o_q_valid,
    input  wire logic i_q_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    function automatic t_cls classify(input logic [7:0] b, input logic last);
        t_cls c;
        logic is_dig;
        logic is_let;
        is_dig     = (b >= CH_DIG_0) && (b <= CH_DIG_9);
        is_let     = ((b >= CH_LC_A) && (b <= CH_LC_F)) || ((b >= CH_UC_A) && (b <= CH_UC_F));
        c.data     = b;
        c.last     = last;
        c.is_bs    = (b == CH_BACKSLASH);
        c.is_x     = (b == CH_X);
        c.is_ws    = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
        c.is_plus  = (b == CH_PLUS);
        c.is_minus = (b == CH_MINUS);
        c.is_hex   = is_dig || is_let;
        // low nibble is the digit value; letters are offset by nine
        c.hex_val  = b[3:0] + (is_let ? 4'd9 : 4'd0);
        return c;
    endfunction

    t_cls             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push;

    assign i_in.ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign push       = i_in.valid && i_in.ready;
    assign o_q_valid  = (r_count != '0);
    assign o_q_item   = r_mem[r_head];

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (push) begin
            n_tail = (r_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
        end
        if (i_q_pop) begin
            n_head = (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
        end
        if (push && !i_q_pop) begin
            n_count = r_count + 1'b1;
        end else if (!push && i_q_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_tail] <= classify(i_in.in_byte, i_in.in_last);
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> (r_count != '0))
        else $error("queue popped while empty");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_push_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !i_q_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count lost a transfer");

endmodule

`default_nettype wire

/* hw/rtl/esd_back.sv */
// Back end: window of up to four classified bytes, escape resolution, output register.
// Depends on esd_pkg and esd_out_if; fed from the queue in esd_front.
`default_nettype none

module esd_back import esd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cls i_q_item,
    input  wire logic i_q_valid,
    output logic      o_q_pop,
    esd_out_if.source o_out
);

    localparam int BUF_DEPTH = 4;
    localparam int BUF_IDX_W = 2;
    localparam int BUF_CNT_W = 3;
    typedef logic [BUF_CNT_W-1:0] t_bcnt;

    t_cls       r_buf [BUF_DEPTH];
    t_cls       n_buf [BUF_DEPTH];
    t_bcnt      r_cnt, n_cnt;
    logic       r_end, n_end;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    // two-byte hex field of a \x escape
    logic       hex_ok;
    logic       hex_neg;
    logic [7:0] hex_mag;
    logic [7:0] hex_res;

    always_comb begin
        hex_ok  = 1'b0;
        hex_neg = 1'b0;
        hex_mag = '0;
        if (r_buf[2].is_ws) begin
            if (r_buf[3].is_hex) begin
                hex_ok  = 1'b1;
                hex_mag = {4'h0, r_buf[3].hex_val};
            end
        end else if (r_buf[2].is_plus || r_buf[2].is_minus) begin
            hex_neg = r_buf[2].is_minus;
            if (r_buf[3].is_hex) begin
                hex_ok  = 1'b1;
                hex_mag = {4'h0, r_buf[3].hex_val};
            end
        end else if (r_buf[2].is_hex) begin
            hex_ok  = 1'b1;
            hex_mag = r_buf[3].is_hex ? {r_buf[2].hex_val, r_buf[3].hex_val}
                                      : {4'h0, r_buf[2].hex_val};
        end
        hex_res = hex_neg ? (~hex_mag + 8'd1) : hex_mag;
    end

    logic       can_emit;
    t_bcnt      used;
    logic [7:0] emit_byte;
    logic       fire;
    t_bcnt      cnt_after;
    t_bcnt      src;
    logic       pull;

    // next decoded byte, if the window already settles it
    always_comb begin
        can_emit  = 1'b1;
        used      = t_bcnt'(1);
        emit_byte = r_buf[0].data;
        if (r_cnt == '0) begin
            can_emit = 1'b0;
        end else if (!r_buf[0].is_bs) begin
            can_emit = 1'b1;
        end else if (r_cnt < t_bcnt'(2)) begin
            can_emit = r_end;      // lone backslash: literal only at end of string
        end else if (r_buf[1].is_bs) begin
            used = t_bcnt'(2);
        end else if (r_buf[1].is_x) begin
            if (r_cnt < t_bcnt'(BUF_DEPTH)) begin
                can_emit = r_end;  // cut short: backslash goes out literally
            end else if (hex_ok) begin
                used      = t_bcnt'(BUF_DEPTH);
                emit_byte = hex_res;
            end
        end
    end

    assign fire      = can_emit && (!r_out_valid || o_out.ready);
    assign cnt_after = fire ? (r_cnt - used) : r_cnt;
    // next string only enters once the current one has left the window
    assign pull      = i_q_valid && (!r_end || (fire && (cnt_after == '0)))
                       && (cnt_after != t_bcnt'(BUF_DEPTH));
    assign o_q_pop   = pull;

    always_comb begin
        for (int i = 0; i < BUF_DEPTH; i++) begin
            n_buf[i] = r_buf[i];
            src      = t_bcnt'(i) + used;
            if (fire && (src < t_bcnt'(BUF_DEPTH))) begin
                n_buf[i] = r_buf[src[BUF_IDX_W-1:0]];
            end
        end
        if (pull) begin
            n_buf[cnt_after[BUF_IDX_W-1:0]] = i_q_item;
        end
        n_cnt = cnt_after + (pull ? t_bcnt'(1) : t_bcnt'(0));
        n_end = r_end;
        if (pull && i_q_item.last) begin
            n_end = 1'b1;
        end else if (fire && (cnt_after == '0)) begin
            n_end = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_end       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_end <= n_end;
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < BUF_DEPTH; i++) begin
            r_buf[i] <= n_buf[i];
        end
        if (fire) begin
            r_out_byte <= emit_byte;
            r_out_last <= r_end && (cnt_after == '0);
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.out_last = r_out_last;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= t_bcnt'(BUF_DEPTH))
        else $error("window count beyond depth");

    a_end_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_end |-> (r_cnt != '0))
        else $error("end of string flagged on an empty window");

    a_short_bs_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_buf[0].is_bs && (used == t_bcnt'(1)) && r_buf[1].is_x
         && (r_cnt < t_bcnt'(BUF_DEPTH))) |-> r_end)
        else $error("escape resolved before its bytes arrived");

    a_hex_full_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (used == t_bcnt'(BUF_DEPTH))) |-> (r_cnt == t_bcnt'(BUF_DEPTH)))
        else $error("hex escape consumed a partial window");

endmodule

`default_nettype wire

/* hw/rtl/escape_sequence_decoder.sv */
// Top level of the backslash escape decoder: front end with queue, back end with window.
// Depends on esd_pkg, esd_if, esd_front and esd_back.
//
// The decoder takes escaped text one byte per transfer, with a last flag on the final
// byte of each string, and gives the decoded bytes with a last flag on the final decoded
// byte. "\\" becomes one backslash; "\x" and two more bytes become one byte, the two
// bytes read as base-16 text (leading whitespace, optional sign, hex digits up to the
// first non-digit, negative values wrapped to 8 bits). A failed or truncated escape
// sends the backslash out literally and rescans the bytes after it. Input is taken at
// one byte per cycle while the queue has room: the front end classifies each byte and
// parks it in a QUEUE_DEPTH-entry queue; the back end pulls one byte per cycle into a
// four-byte window when it has room and holds no finished string, and settles at most
// one decoded byte per cycle into its output register, so there is never more than one
// result per input byte and the queue absorbs short stalls. In the plain case a byte
// goes from the queue through the window into the output register; an escape resolves
// once its fourth byte is in the window, or once the string's last byte is there. Bytes
// the window holds back when a string ends are flushed one per cycle unless the output
// stalls, before the next string enters. Back-pressure on the output holds the window,
// while the queue keeps accepting until full. No clearing pass is needed after reset.
`default_nettype none

module escape_sequence_decoder import esd_pkg::*; #(
    parameter int QUEUE_DEPTH = ESD_QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    esd_in_if.sink    i_in,
    esd_out_if.source o_out
);

    // classified bytes between front and back
    t_cls q_item;
    logic q_valid;
    logic q_pop;

    esd_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_item  (q_item),
        .o_q_valid (q_valid),
        .i_q_pop   (q_pop)
    );

    esd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_item  (q_item),
        .i_q_valid (q_valid),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire
